/* hdl/assert_macros.svh */
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sths_pkg.sv */
package sths_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 2 * CAPACITY + 1;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  localparam int VAL_W  = 32;
  localparam int POS_W  = 4;
  localparam int KIND_W = 2;

  localparam int OUT_FIELDS_W = POS_W + VAL_W + 2;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  localparam logic [KIND_W-1:0] KIND_ELEM  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MATCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRT_I,
    ST_SRT_F,
    ST_SRT_J,
    ST_SRT_W,
    ST_EM_RD,
    ST_EM_OUT,
    ST_MID_RD,
    ST_MID_CMP,
    ST_SC_RD,
    ST_SC_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  element;
    logic              found;
    logic              overflow;
    logic              last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } emit_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

/* hdl/sort_then_half_split_search.sv */
// channel  dir  handshake         tdata                     tuser  tlast
// in_      in   in_tvalid/tready  value                     func   -
// out_     out  out_tvalid/tready position element found    kind   last
//                                 overflow
//
// a load item causes no result and leaves the input ready for the next item
// a search over n stored items runs an exchange sort (one store read and one
// compare per pair), then emits each sorted element, probes the middle, scans
// one half entry by entry when the middle does not match, and ends with done,
// with in_tready low throughout
// rst_n clears the item count and flags; store contents are kept
// a stalled out_tready holds the sequencer on the pending item

module sort_then_half_split_search
  import sths_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [VAL_W-1:0]      in_tdata,   // value
  input  logic                  in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // position, element, found, overflow, pad
  output logic [KIND_W-1:0]     out_tuser,  // kind
  output logic                  out_tlast
);

  logic             room;
  emit_t            emit;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [VAL_W-1:0] ram_rdata;
  logic [VAL_W-1:0] cmp_a;
  cmp_t             cmp;

  logic             out_valid_r;
  result_t          out_res_r;

  sths_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_func   (in_tuser),
    .in_value  (in_tdata),
    .in_ready  (in_tready),
    .room      (room),
    .emit      (emit),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .cmp_a     (cmp_a),
    .cmp       (cmp)
  );

  sths_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sths_cmp u_cmp (
    .a   (cmp_a),
    .b   (ram_rdata),
    .res (cmp)
  );

  // output register
  assign room = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (room) begin
      out_valid_r <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (room && emit.valid) begin
      out_res_r <= emit.res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_res_r.overflow, out_res_r.found,
                       out_res_r.element, out_res_r.position};

endmodule

/* hdl/sths_ram.sv */
module sths_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/sths_cmp.sv */
module sths_cmp
  import sths_pkg::*;
(
  input  logic [VAL_W-1:0] a,
  input  logic [VAL_W-1:0] b,
  output cmp_t             res
);

  // signed q16.16 compare
  always_comb begin
    res.lt = $signed(a) < $signed(b);
    res.eq = (a == b);
  end

endmodule

/* hdl/sths_seq.sv */
module sths_seq
  import sths_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_func,
  input  logic [VAL_W-1:0] in_value,
  output logic             in_ready,
  input  logic             room,
  output emit_t            emit,
  output logic             ram_we,
  output logic [IDX_W-1:0] ram_waddr,
  output logic [VAL_W-1:0] ram_wdata,
  output logic [IDX_W-1:0] ram_raddr,
  input  logic [VAL_W-1:0] ram_rdata,
  output logic [VAL_W-1:0] cmp_a,
  input  cmp_t             cmp
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             drop_r, drop_nxt;
  logic [VAL_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic             found_r, found_nxt;
  logic [RES_W-1:0] nres_r, nres_nxt;

  logic [CNT_W-1:0] j_inc;
  logic [CNT_W-1:0] i_inc;
  logic [CNT_W-1:0] mid;
  logic             can_emit;
  logic             go;

  assign j_inc    = j_r + 1'b1;
  assign i_inc    = i_r + 1'b1;
  assign mid      = cnt_r >> 1;
  assign can_emit = nres_r < RES_W'(MAX_RESULTS - 1);
  // a result that no longer fits is skipped and needs no room
  assign go       = room || !can_emit;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_func == FUNC_SEARCH) begin
          state_nxt = (cnt_r == '0) ? ST_DONE : ST_SRT_I;
        end
      end
      ST_SRT_I: state_nxt = ST_SRT_F;
      ST_SRT_F: state_nxt = ST_SRT_J;
      ST_SRT_J: begin
        if (j_inc == cnt_r) begin
          state_nxt = ST_SRT_W;
        end
      end
      ST_SRT_W: state_nxt = (i_inc == cnt_r) ? ST_EM_RD : ST_SRT_I;
      ST_EM_RD: state_nxt = ST_EM_OUT;
      ST_EM_OUT: begin
        if (go) begin
          state_nxt = (j_inc == cnt_r) ? ST_MID_RD : ST_EM_RD;
        end
      end
      ST_MID_RD: state_nxt = ST_MID_CMP;
      ST_MID_CMP: begin
        if (cmp.eq) begin
          if (go) begin
            state_nxt = ST_DONE;
          end
        end else begin
          state_nxt = ST_SC_RD;
        end
      end
      ST_SC_RD: state_nxt = (j_r == hi_r) ? ST_DONE : ST_SC_CMP;
      ST_SC_CMP: begin
        if (!cmp.eq || go) begin
          state_nxt = ST_SC_RD;
        end
      end
      ST_DONE: begin
        if (room) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    key_nxt   = key_r;
    cur_nxt   = cur_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    hi_nxt    = hi_r;
    found_nxt = found_r;
    nres_nxt  = nres_r;
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = i_r[IDX_W-1:0];
    ram_wdata = cur_r;
    ram_raddr = j_r[IDX_W-1:0];
    cmp_a     = key_r;
    emit      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FUNC_SEARCH) begin
            key_nxt   = in_value;
            i_nxt     = '0;
            j_nxt     = '0;
            found_nxt = 1'b0;
            nres_nxt  = '0;
          end else if (cnt_r < CNT_W'(CAPACITY)) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_r[IDX_W-1:0];
            ram_wdata = in_value;
            cnt_nxt   = cnt_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
        end
      end
      ST_SRT_I: begin
        ram_raddr = i_r[IDX_W-1:0];
        j_nxt     = '0;
      end
      ST_SRT_F: begin
        cur_nxt = ram_rdata;
      end
      ST_SRT_J: begin
        // entry i lives in cur_r for the whole inner pass
        cmp_a     = cur_r;
        ram_raddr = j_inc[IDX_W-1:0];
        if (j_r != i_r && cmp.lt) begin
          ram_we    = 1'b1;
          ram_waddr = j_r[IDX_W-1:0];
          ram_wdata = cur_r;
          cur_nxt   = ram_rdata;
        end
        j_nxt = j_inc;
      end
      ST_SRT_W: begin
        ram_we = 1'b1;
        i_nxt  = i_inc;
        j_nxt  = '0;
      end
      ST_EM_RD: begin
      end
      ST_EM_OUT: begin
        emit.valid        = can_emit;
        emit.res.kind     = KIND_ELEM;
        emit.res.position = POS_W'(j_r);
        emit.res.element  = ram_rdata;
        if (go) begin
          j_nxt = j_inc;
          if (can_emit) begin
            nres_nxt = nres_r + 1'b1;
          end
        end
      end
      ST_MID_RD: begin
        ram_raddr = mid[IDX_W-1:0];
      end
      ST_MID_CMP: begin
        ram_raddr = mid[IDX_W-1:0];
        if (cmp.eq) begin
          found_nxt         = 1'b1;
          emit.valid        = can_emit;
          emit.res.kind     = KIND_MATCH;
          emit.res.position = POS_W'(mid);
          emit.res.element  = key_r;
          if (go && can_emit) begin
            nres_nxt = nres_r + 1'b1;
          end
        end else if (cmp.lt) begin
          j_nxt  = '0;
          hi_nxt = mid;
        end else begin
          j_nxt  = mid;
          hi_nxt = cnt_r;
        end
      end
      ST_SC_RD: begin
      end
      ST_SC_CMP: begin
        if (cmp.eq) begin
          found_nxt         = 1'b1;
          emit.valid        = can_emit;
          emit.res.kind     = KIND_MATCH;
          emit.res.position = POS_W'(j_r);
          emit.res.element  = key_r;
          if (go) begin
            j_nxt = j_inc;
            if (can_emit) begin
              nres_nxt = nres_r + 1'b1;
            end
          end
        end else begin
          j_nxt = j_inc;
        end
      end
      ST_DONE: begin
        emit.valid        = 1'b1;
        emit.res.kind     = KIND_DONE;
        emit.res.found    = found_r;
        emit.res.overflow = drop_r;
        emit.res.last     = 1'b1;
        if (room) begin
          cnt_nxt  = '0;
          drop_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      found_r <= 1'b0;
      nres_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      found_r <= found_nxt;
      nres_r  <= nres_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    cur_r <= cur_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    hi_r  <= hi_nxt;
  end

endmodule

/* hdl/sths_chk.sv */
`include "assert_macros.svh"

module sths_chk
  import sths_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [KIND_W-1:0]     out_tuser,
  input logic                  out_tlast
);

  logic search_acc;
  logic load_acc;

  assign search_acc = in_tvalid && in_tready && in_tuser == FUNC_SEARCH;
  assign load_acc   = in_tvalid && in_tready && in_tuser == FUNC_LOAD;

  `CHK_IMPLY(a_last_is_done, out_tvalid && out_tlast, out_tuser == KIND_DONE, "last item not done")
  `CHK_IMPLY(a_busy_mid_run, out_tvalid && !out_tlast, !in_tready, "input open mid run")
  `CHK_NEXT(a_search_busy, search_acc, !in_tready, "input open after search")
  `CHK_NEXT(a_load_ready, load_acc, in_tready, "input closed after load")
  `CHK_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled item moved")

endmodule

bind sort_then_half_split_search sths_chk u_chk (.*);

/* sim/tb_sort_then_half_split_search.sv */
`timescale 1ns / 1ps

module tb_sort_then_half_split_search;
  import sths_pkg::*;

  typedef struct {
    logic              func;
    logic [VAL_W-1:0]  value;
    bit                drain;
    bit                steady;
  } stim_item_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [VAL_W-1:0]      in_tdata = '0;
  logic                  in_tuser = FUNC_LOAD;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;

  stim_item_t       stim_queue[$];
  result_t          search_results[$];
  logic [VAL_W-1:0] sorted_store[CAPACITY];
  int unsigned      stored_count = 0;
  logic             dropped_loads = 1'b0;
  int               results_this_search;
  int               mismatches = 0;
  bit               offered = 1'b0;
  bit               steady_mode = 1'b0;

  sort_then_half_split_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [VAL_W-1:0] got,
                               input logic [VAL_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  task automatic push_result(input logic [KIND_W-1:0] kind, input int unsigned pos,
                             input logic [VAL_W-1:0] elem, input logic found,
                             input logic ovf, input logic last);
    result_t r;
    if (!last && results_this_search >= MAX_RESULTS - 1) return;
    if (results_this_search >= MAX_RESULTS) return;
    r.kind     = kind;
    r.position = POS_W'(pos);
    r.element  = elem;
    r.found    = found;
    r.overflow = ovf;
    r.last     = last;
    search_results.push_back(r);
    results_this_search++;
  endtask

  task automatic predict_search(input logic [VAL_W-1:0] key);
    int unsigned      cnt;
    int unsigned      mid;
    logic [VAL_W-1:0] tmp;
    logic [VAL_W-1:0] middle;
    logic             hit;
    hit = 1'b0;
    results_this_search = 0;
    cnt = (stored_count > CAPACITY) ? CAPACITY : stored_count;
    // all-pairs exchange, same pass order as the block
    for (int unsigned i = 0; i < cnt; i++) begin
      for (int unsigned j = 0; j < cnt; j++) begin
        if ($signed(sorted_store[i]) < $signed(sorted_store[j])) begin
          tmp = sorted_store[i];
          sorted_store[i] = sorted_store[j];
          sorted_store[j] = tmp;
        end
      end
    end
    for (int unsigned i = 0; i < cnt; i++) begin
      push_result(KIND_ELEM, i, sorted_store[i], 1'b0, 1'b0, 1'b0);
    end
    if (cnt > 0) begin
      mid = cnt / 2;
      middle = sorted_store[mid];
      if (middle == key) begin
        hit = 1'b1;
        push_result(KIND_MATCH, mid, key, 1'b0, 1'b0, 1'b0);
      end else if ($signed(key) < $signed(middle)) begin
        for (int unsigned i = 0; i < mid; i++) begin
          if (sorted_store[i] == key) begin
            hit = 1'b1;
            push_result(KIND_MATCH, i, key, 1'b0, 1'b0, 1'b0);
          end
        end
      end else begin
        for (int unsigned i = mid; i < cnt; i++) begin
          if (sorted_store[i] == key) begin
            hit = 1'b1;
            push_result(KIND_MATCH, i, key, 1'b0, 1'b0, 1'b0);
          end
        end
      end
    end
    push_result(KIND_DONE, 0, '0, hit, dropped_loads, 1'b1);
    stored_count = 0;
    dropped_loads = 1'b0;
  endtask

  task automatic apply_item(input logic func, input logic [VAL_W-1:0] value);
    if (func == FUNC_LOAD) begin
      if (stored_count < CAPACITY) begin
        sorted_store[stored_count] = value;
        stored_count++;
      end else begin
        dropped_loads = 1'b1;
      end
    end else begin
      predict_search(value);
    end
  endtask

  task automatic queue_item(input logic func, input logic [VAL_W-1:0] value,
                            input bit drain, input bit steady);
    stim_item_t it;
    it.func   = func;
    it.value  = value;
    it.drain  = drain;
    it.steady = steady;
    stim_queue.push_back(it);
  endtask

  function automatic logic [VAL_W-1:0] random_value();
    int k;
    case ($urandom_range(3))
      0: return $urandom();
      1: begin
        k = int'($urandom_range(8)) - 4;
        return VAL_W'(k) << 16;
      end
      2: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return VAL_W'($urandom_range(3));
    endcase
  endfunction

  task automatic queue_random_run(input bit first, input bit steady);
    int               r;
    int               size;
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] key;
    logic [VAL_W-1:0] vals[$];
    r = $urandom_range(99);
    if (r < 60) size = $urandom_range(1, 6);
    else if (r < 85) size = $urandom_range(7, CAPACITY);
    else if (r < 95) size = $urandom_range(CAPACITY + 1, CAPACITY + 4);
    else size = 0;
    for (int k = 0; k < size; k++) begin
      v = random_value();
      vals.push_back(v);
      queue_item(FUNC_LOAD, v, first && k == 0, steady);
    end
    if (vals.size() > 0 && $urandom_range(99) < 55) key = vals[$urandom_range(vals.size() - 1)];
    else key = random_value();
    queue_item(FUNC_SEARCH, key, (first && size == 0) || $urandom_range(99) < 5, steady);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_item(stim_queue[0].func, stim_queue[0].value);
        void'(stim_queue.pop_front());
        offered = 1'b0;
      end
      if (!offered) begin
        if (stim_queue.size() > 0 && !(stim_queue[0].drain && search_results.size() > 0) &&
            (stim_queue[0].steady || $urandom_range(99) >= 34)) begin
          in_tdata    <= stim_queue[0].value;
          in_tuser    <= stim_queue[0].func;
          in_tvalid   <= 1'b1;
          steady_mode <= stim_queue[0].steady;
          offered = 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (search_results.size() == 0) begin
          report_mismatch($sformatf("unexpected item kind %0d data %0h", out_tuser, out_tdata));
        end else begin
          want = search_results.pop_front();
          compare_field("kind", VAL_W'(out_tuser), VAL_W'(want.kind));
          compare_field("position", VAL_W'(out_tdata[POS_W-1:0]), VAL_W'(want.position));
          compare_field("element", out_tdata[POS_W +: VAL_W], want.element);
          compare_field("found", VAL_W'(out_tdata[POS_W+VAL_W]), VAL_W'(want.found));
          compare_field("overflow", VAL_W'(out_tdata[POS_W+VAL_W+1]), VAL_W'(want.overflow));
          compare_field("last", VAL_W'(out_tlast), VAL_W'(want.last));
        end
      end
      out_tready <= steady_mode || ($urandom_range(99) >= 34);
    end
  end

  initial begin
    int run_idx;
    // empty store
    queue_item(FUNC_SEARCH, 32'h0000_0000, 1'b0, 1'b0);
    // extremes, key equal to the middle
    queue_item(FUNC_LOAD, 32'h8000_0000, 1'b0, 1'b0);
    queue_item(FUNC_LOAD, 32'h7FFF_FFFF, 1'b0, 1'b0);
    queue_item(FUNC_LOAD, 32'h0000_0000, 1'b0, 1'b0);
    queue_item(FUNC_LOAD, 32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_item(FUNC_SEARCH, 32'h0000_0000, 1'b0, 1'b0);
    // lower half scan with duplicates
    queue_item(FUNC_LOAD, 32'h0003_0000, 1'b0, 1'b0);
    queue_item(FUNC_LOAD, 32'h0001_0000, 1'b0, 1'b0);
    queue_item(FUNC_LOAD, 32'h0001_0000, 1'b0, 1'b0);
    queue_item(FUNC_LOAD, 32'h0002_0000, 1'b0, 1'b0);
    queue_item(FUNC_LOAD, 32'h0005_0000, 1'b0, 1'b0);
    queue_item(FUNC_SEARCH, 32'h0001_0000, 1'b0, 1'b0);
    // duplicates on the middle, only the middle is reported
    queue_item(FUNC_LOAD, 32'h0005_0000, 1'b0, 1'b0);
    queue_item(FUNC_LOAD, 32'h0007_0000, 1'b0, 1'b0);
    queue_item(FUNC_LOAD, 32'h0007_0000, 1'b0, 1'b0);
    queue_item(FUNC_SEARCH, 32'h0007_0000, 1'b0, 1'b0);
    // upper half scan
    queue_item(FUNC_LOAD, 32'h0002_0000, 1'b0, 1'b0);
    queue_item(FUNC_LOAD, 32'h0009_0000, 1'b0, 1'b0);
    queue_item(FUNC_LOAD, 32'h0004_0000, 1'b0, 1'b0);
    queue_item(FUNC_LOAD, 32'h0009_0000, 1'b0, 1'b0);
    queue_item(FUNC_LOAD, 32'h0008_0000, 1'b0, 1'b0);
    queue_item(FUNC_SEARCH, 32'h0009_0000, 1'b0, 1'b0);
    // single entry, no match
    queue_item(FUNC_LOAD, 32'hFFFF_0000, 1'b0, 1'b0);
    queue_item(FUNC_SEARCH, 32'h1234_5678, 1'b0, 1'b0);
    run_idx = 0;
    while (stim_queue.size() < 150) begin
      queue_random_run(run_idx == 0, run_idx >= 10 && run_idx < 16);
      run_idx++;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (stim_queue.size() > 0 || search_results.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && search_results.size() == 0) begin
      $display("[sort_then_half_split_search] OK");
    end else begin
      $display("[sort_then_half_split_search] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[sort_then_half_split_search] ERROR");
    $finish;
  end

endmodule
